>>> hdl/fsmc_pkg.sv
// Shared types, constants and opcodes of the Forth stack machine core.
package fsmc_pkg;

    localparam int RAM_BYTES   = 32768;
    localparam int FLASH_BYTES = 65536;
    localparam int RAM_AW      = $clog2(RAM_BYTES);
    localparam int FLASH_AW    = $clog2(FLASH_BYTES);

    localparam int CELL_W = 24;
    localparam int IN_W   = 40;
    localparam int USER_W = 2;
    localparam int OUT_W  = 72;

    localparam logic [CELL_W-1:0] FLASH_BIT   = 24'h800000;
    localparam logic [CELL_W-1:0] RAM_TAG     = 24'h400000;
    localparam logic [CELL_W-1:0] RSTACK_BASE = 24'h001000;
    localparam logic [CELL_W-1:0] DSTACK_BASE = 24'h002000;
    localparam logic [CELL_W-1:0] CELL_TRUE   = 24'hffffff;
    localparam logic [CELL_W-1:0] KEY_VECTOR  = 24'h800003;
    localparam logic [CELL_W-1:0] CELL_THREE  = 24'd3;
    localparam logic [CELL_W-1:0] CELL_SIX    = 24'd6;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EXEC  = 2'd2;
    localparam logic [1:0] REQ_KEY   = 2'd3;

    localparam logic [4:0] OP_EXIT    = 5'd0;
    localparam logic [4:0] OP_JUMP    = 5'd1;
    localparam logic [4:0] OP_LIT     = 5'd2;
    localparam logic [4:0] OP_BRZ     = 5'd3;
    localparam logic [4:0] OP_TOR     = 5'd4;
    localparam logic [4:0] OP_RFETCH  = 5'd5;
    localparam logic [4:0] OP_RDROP   = 5'd6;
    localparam logic [4:0] OP_DUP     = 5'd7;
    localparam logic [4:0] OP_DROP    = 5'd8;
    localparam logic [4:0] OP_SWAP    = 5'd9;
    localparam logic [4:0] OP_OVER    = 5'd10;
    localparam logic [4:0] OP_LESS    = 5'd11;
    localparam logic [4:0] OP_ZEQ     = 5'd12;
    localparam logic [4:0] OP_ADD     = 5'd13;
    localparam logic [4:0] OP_SHR     = 5'd14;
    localparam logic [4:0] OP_AND     = 5'd15;
    localparam logic [4:0] OP_OR      = 5'd16;
    localparam logic [4:0] OP_XOR     = 5'd17;
    localparam logic [4:0] OP_CFETCH  = 5'd18;
    localparam logic [4:0] OP_CSTORE  = 5'd19;
    localparam logic [4:0] OP_WSTORE  = 5'd20;
    localparam logic [4:0] OP_WFETCH  = 5'd21;
    localparam logic [4:0] OP_FETCH   = 5'd22;
    localparam logic [4:0] OP_STORE   = 5'd23;
    localparam logic [4:0] OP_KEY     = 5'd24;
    localparam logic [4:0] OP_EMIT    = 5'd25;
    localparam logic [4:0] OP_SPI     = 5'd26;
    localparam logic [4:0] OP_PWM     = 5'd27;
    localparam logic [4:0] OP_B9600   = 5'd28;
    localparam logic [4:0] OP_B38400  = 5'd29;
    localparam logic [4:0] OP_SLEEP   = 5'd30;

    typedef enum logic [1:0] {MEM_NONE, MEM_RD, MEM_WR} mem_op_t;
    typedef enum logic [2:0] {A_IP, A_DSP, A_DSP3, A_RSP, A_C, A_MDR, A_EXT} addr_sel_t;
    typedef enum logic [2:0] {W_IP, W_MDR, W_C, W_ALU, W_KEY, W_EXT} wr_sel_t;
    typedef enum logic [2:0] {IP_HOLD, IP_INC, IP_PEND, IP_MDR, IP_OP} ip_sel_t;
    typedef enum logic [1:0] {SP_HOLD, SP_INC3, SP_DEC3, SP_INC6} sp_sel_t;

    typedef struct packed {
        logic      in_ld;
        mem_op_t   mem_op;
        logic [1:0] mem_n;
        addr_sel_t addr_sel;
        wr_sel_t   wr_sel;
        logic      flash_ok;
        ip_sel_t   ip_sel;
        sp_sel_t   dsp_sel;
        sp_sel_t   rsp_sel;
        logic      pend_clr;
        logic      key_ld;
        logic      op_ld;
        logic      c_ld;
        logic      rd_ld;
        logic      tx_set;
        logic      pv_set;
        logic      baud_set;
        logic      sleep_set;
        logic      res_ld;
    } cmd_t;

    typedef struct packed {
        logic       busy;
        logic       is_call;
        logic       op_small;
        logic [4:0] op_code;
        logic       mdr_zero;
        logic       pend_nz;
        logic [1:0] req;
    } status_t;

endpackage

>>> hdl/fsmc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module fsmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fsmc_datapath.sv
// Datapath: machine registers, ALU, byte-serial memory engine, RAM and flash.
module fsmc_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fsmc_pkg::cmd_t             cmd,
    output fsmc_pkg::status_t          sts,
    input  logic [fsmc_pkg::IN_W-1:0]  s_tdata,
    input  logic [fsmc_pkg::USER_W-1:0] s_tuser,
    output logic [fsmc_pkg::OUT_W-1:0] m_tdata
);

    logic [23:0] ip_reg, ip_next, dsp_reg, dsp_next, rsp_reg, rsp_next;
    logic [23:0] pend_reg, pend_next;
    logic [7:0]  key_reg, key_next;
    logic [23:0] op_reg, op_next, c_reg, c_next, mdr_reg, mdr_next;
    logic [1:0]  req_reg, req_next;
    logic [23:0] xaddr_reg, xaddr_next;
    logic [7:0]  xwd_reg, xwd_next;
    logic        xtxr_reg, xtxr_next;
    logic [7:0]  rd_reg, rd_next, txd_reg, txd_next;
    logic        txv_reg, txv_next, pv_reg, pv_next, bv_reg, bv_next;
    logic        bf_reg, bf_next, sl_reg, sl_next;
    logic [23:0] pa_reg, pa_next;
    logic [fsmc_pkg::OUT_W-1:0] out_reg, out_next;

    logic        rd_act_reg, rd_act_next, wr_act_reg, wr_act_next;
    logic        cap_reg, cap_next, eflash_reg, eflash_next;
    logic [1:0]  cnt_reg, cnt_next, n_reg, n_next, cap_idx_reg, cap_idx_next;
    logic [23:0] eaddr_reg, eaddr_next, ewdata_reg, ewdata_next;

    logic [23:0] maddr, wval, alu;
    logic [7:0]  ram_rdata, flash_rdata, rbyte;

    always_comb begin
        case (cmd.addr_sel)
            fsmc_pkg::A_IP:   maddr = ip_reg;
            fsmc_pkg::A_DSP:  maddr = dsp_reg;
            fsmc_pkg::A_DSP3: maddr = dsp_reg + fsmc_pkg::CELL_THREE;
            fsmc_pkg::A_RSP:  maddr = rsp_reg;
            fsmc_pkg::A_C:    maddr = c_reg;
            fsmc_pkg::A_MDR:  maddr = mdr_reg;
            fsmc_pkg::A_EXT:  maddr = xaddr_reg;
            default:          maddr = ip_reg;
        endcase
    end

    always_comb begin
        case (op_reg[4:0])
            fsmc_pkg::OP_LESS: alu = (mdr_reg < c_reg) ? fsmc_pkg::CELL_TRUE : 24'd0;
            fsmc_pkg::OP_ZEQ:  alu = (mdr_reg == 24'd0) ? fsmc_pkg::CELL_TRUE : 24'd0;
            fsmc_pkg::OP_ADD:  alu = mdr_reg + c_reg;
            fsmc_pkg::OP_SHR:  alu = mdr_reg >> 1;
            fsmc_pkg::OP_AND:  alu = mdr_reg & c_reg;
            fsmc_pkg::OP_OR:   alu = mdr_reg | c_reg;
            fsmc_pkg::OP_XOR:  alu = mdr_reg ^ c_reg;
            fsmc_pkg::OP_EMIT: alu = xtxr_reg ? fsmc_pkg::CELL_TRUE : 24'd0;
            default:           alu = mdr_reg;
        endcase
    end

    always_comb begin
        case (cmd.wr_sel)
            fsmc_pkg::W_IP:  wval = ip_reg;
            fsmc_pkg::W_MDR: wval = mdr_reg;
            fsmc_pkg::W_C:   wval = c_reg;
            fsmc_pkg::W_ALU: wval = alu;
            fsmc_pkg::W_KEY: wval = {16'd0, key_reg};
            fsmc_pkg::W_EXT: wval = {16'd0, xwd_reg};
            default:         wval = mdr_reg;
        endcase
    end

    assign rbyte = eflash_reg ? flash_rdata : ram_rdata;

    always_comb begin
        rd_act_next  = rd_act_reg;
        wr_act_next  = wr_act_reg;
        cap_next     = 1'b0;
        cap_idx_next = cap_idx_reg;
        eflash_next  = eflash_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        eaddr_next   = eaddr_reg;
        ewdata_next  = ewdata_reg;
        mdr_next     = mdr_reg;
        if (cap_reg) begin
            case (cap_idx_reg)
                2'd0:    mdr_next[7:0]   = rbyte;
                2'd1:    mdr_next[15:8]  = rbyte;
                default: mdr_next[23:16] = rbyte;
            endcase
        end
        if (cmd.mem_op == fsmc_pkg::MEM_RD) begin
            eaddr_next  = maddr;
            eflash_next = maddr[23];
            n_next      = cmd.mem_n;
            cnt_next    = 2'd0;
            rd_act_next = 1'b1;
            mdr_next    = 24'd0;
        end else if (cmd.mem_op == fsmc_pkg::MEM_WR) begin
            eaddr_next  = maddr;
            eflash_next = maddr[23];
            n_next      = cmd.mem_n;
            cnt_next    = 2'd0;
            ewdata_next = wval;
            wr_act_next = !(maddr[23] && !cmd.flash_ok);
        end else if (rd_act_reg || wr_act_reg) begin
            eaddr_next  = eaddr_reg + 24'd1;
            cnt_next    = cnt_reg + 2'd1;
            ewdata_next = ewdata_reg >> 8;
            if (rd_act_reg) begin
                cap_next     = 1'b1;
                cap_idx_next = cnt_reg;
            end
            if (cnt_reg == n_reg - 2'd1) begin
                rd_act_next = 1'b0;
                wr_act_next = 1'b0;
            end
        end
    end

    always_comb begin
        ip_next = ip_reg;
        case (cmd.ip_sel)
            fsmc_pkg::IP_INC:  ip_next = ip_reg + fsmc_pkg::CELL_THREE;
            fsmc_pkg::IP_PEND: ip_next = pend_reg;
            fsmc_pkg::IP_MDR:  ip_next = mdr_reg;
            fsmc_pkg::IP_OP:   ip_next = op_reg;
            default:           ip_next = ip_reg;
        endcase
        case (cmd.dsp_sel)
            fsmc_pkg::SP_INC3: dsp_next = dsp_reg + fsmc_pkg::CELL_THREE;
            fsmc_pkg::SP_DEC3: dsp_next = dsp_reg - fsmc_pkg::CELL_THREE;
            fsmc_pkg::SP_INC6: dsp_next = dsp_reg + fsmc_pkg::CELL_SIX;
            default:           dsp_next = dsp_reg;
        endcase
        case (cmd.rsp_sel)
            fsmc_pkg::SP_INC3: rsp_next = rsp_reg + fsmc_pkg::CELL_THREE;
            fsmc_pkg::SP_DEC3: rsp_next = rsp_reg - fsmc_pkg::CELL_THREE;
            fsmc_pkg::SP_INC6: rsp_next = rsp_reg + fsmc_pkg::CELL_SIX;
            default:           rsp_next = rsp_reg;
        endcase
        pend_next  = pend_reg;
        key_next   = key_reg;
        if (cmd.key_ld) begin
            key_next  = xwd_reg;
            pend_next = fsmc_pkg::KEY_VECTOR;
        end else if (cmd.pend_clr) begin
            pend_next = 24'd0;
        end
        op_next = cmd.op_ld ? mdr_reg : op_reg;
        c_next  = cmd.c_ld ? mdr_reg : c_reg;

        req_next   = req_reg;
        xaddr_next = xaddr_reg;
        xwd_next   = xwd_reg;
        xtxr_next  = xtxr_reg;
        rd_next    = rd_reg;
        txv_next   = txv_reg;
        txd_next   = txd_reg;
        pv_next    = pv_reg;
        pa_next    = pa_reg;
        bv_next    = bv_reg;
        bf_next    = bf_reg;
        sl_next    = sl_reg;
        if (cmd.in_ld) begin
            req_next   = s_tuser;
            xaddr_next = s_tdata[23:0];
            xwd_next   = s_tdata[31:24];
            xtxr_next  = s_tdata[32];
            rd_next    = 8'd0;
            txv_next   = 1'b0;
            txd_next   = 8'd0;
            pv_next    = 1'b0;
            pa_next    = 24'd0;
            bv_next    = 1'b0;
            bf_next    = 1'b0;
            sl_next    = 1'b0;
        end
        if (cmd.rd_ld) begin
            rd_next = mdr_reg[7:0];
        end
        if (cmd.tx_set) begin
            txv_next = xtxr_reg;
            txd_next = xtxr_reg ? mdr_reg[7:0] : 8'd0;
        end
        if (cmd.pv_set) begin
            pv_next = 1'b1;
            pa_next = mdr_reg;
        end
        if (cmd.baud_set) begin
            bv_next = 1'b1;
            bf_next = (op_reg[4:0] == fsmc_pkg::OP_B38400);
        end
        if (cmd.sleep_set) begin
            sl_next = 1'b1;
        end
        out_next = out_reg;
        if (cmd.res_ld) begin
            out_next = {3'b000, sl_reg, bf_reg, bv_reg, pa_reg, pv_reg, txd_reg, txv_reg,
                        ip_reg, rd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg     <= 24'd0;
            dsp_reg    <= fsmc_pkg::RAM_TAG | fsmc_pkg::DSTACK_BASE;
            rsp_reg    <= fsmc_pkg::RAM_TAG | fsmc_pkg::RSTACK_BASE;
            pend_reg   <= fsmc_pkg::FLASH_BIT;
            key_reg    <= 8'd0;
            rd_act_reg <= 1'b0;
            wr_act_reg <= 1'b0;
            cap_reg    <= 1'b0;
        end else begin
            ip_reg     <= ip_next;
            dsp_reg    <= dsp_next;
            rsp_reg    <= rsp_next;
            pend_reg   <= pend_next;
            key_reg    <= key_next;
            rd_act_reg <= rd_act_next;
            wr_act_reg <= wr_act_next;
            cap_reg    <= cap_next;
        end
        op_reg      <= op_next;
        c_reg       <= c_next;
        mdr_reg     <= mdr_next;
        req_reg     <= req_next;
        xaddr_reg   <= xaddr_next;
        xwd_reg     <= xwd_next;
        xtxr_reg    <= xtxr_next;
        rd_reg      <= rd_next;
        txv_reg     <= txv_next;
        txd_reg     <= txd_next;
        pv_reg      <= pv_next;
        pa_reg      <= pa_next;
        bv_reg      <= bv_next;
        bf_reg      <= bf_next;
        sl_reg      <= sl_next;
        out_reg     <= out_next;
        cap_idx_reg <= cap_idx_next;
        eflash_reg  <= eflash_next;
        cnt_reg     <= cnt_next;
        n_reg       <= n_next;
        eaddr_reg   <= eaddr_next;
        ewdata_reg  <= ewdata_next;
    end

    fsmc_ram #(.WIDTH(8), .DEPTH(fsmc_pkg::RAM_BYTES)) u_ram (
        .clk   (aclk),
        .we    (wr_act_reg && !eflash_reg),
        .waddr (eaddr_reg[fsmc_pkg::RAM_AW-1:0]),
        .wdata (ewdata_reg[7:0]),
        .raddr (eaddr_reg[fsmc_pkg::RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    fsmc_ram #(.WIDTH(8), .DEPTH(fsmc_pkg::FLASH_BYTES)) u_flash (
        .clk   (aclk),
        .we    (wr_act_reg && eflash_reg),
        .waddr (eaddr_reg[fsmc_pkg::FLASH_AW-1:0]),
        .wdata (ewdata_reg[7:0]),
        .raddr (eaddr_reg[fsmc_pkg::FLASH_AW-1:0]),
        .rdata (flash_rdata)
    );

    assign sts.busy     = rd_act_reg || wr_act_reg || cap_reg;
    assign sts.is_call  = |op_reg[23:22];
    assign sts.op_small = (op_reg[23:5] == 19'd0);
    assign sts.op_code  = op_reg[4:0];
    assign sts.mdr_zero = (mdr_reg == 24'd0);
    assign sts.pend_nz  = (pend_reg != 24'd0);
    assign sts.req      = req_reg;
    assign m_tdata      = out_reg;

endmodule

>>> hdl/fsmc_ctrl.sv
// Controller: sequences requests and opcodes into datapath commands.
module fsmc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  fsmc_pkg::status_t   sts,
    output fsmc_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_RDX, ST_IRQ_WR, ST_FETCH, ST_DECODE, ST_EXEC,
        ST_CALL_WR, ST_LD_IP, ST_PUSH, ST_PUSH_W, ST_BR, ST_RPUSH, ST_RPUSH_W,
        ST_SW1, ST_SW2, ST_SW3, ST_BIN1, ST_ALU_W, ST_FETCHT, ST_TOP_W,
        ST_ST1, ST_ST2, ST_KEY_W, ST_PWM, ST_WAIT, ST_DONE
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic [1:0] size_n;

    always_comb begin
        case (sts.op_code)
            fsmc_pkg::OP_CFETCH, fsmc_pkg::OP_CSTORE: size_n = 2'd1;
            fsmc_pkg::OP_WFETCH, fsmc_pkg::OP_WSTORE: size_n = 2'd2;
            default:                                  size_n = 2'd3;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.mem_n  = 2'd3;
        state_next = state_reg;
        ret_next   = ret_reg;
        s_tready   = (state_reg == ST_IDLE);
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_ld  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.req)
                    fsmc_pkg::REQ_WRITE: begin
                        cmd.mem_op   = fsmc_pkg::MEM_WR;
                        cmd.mem_n    = 2'd1;
                        cmd.addr_sel = fsmc_pkg::A_EXT;
                        cmd.wr_sel   = fsmc_pkg::W_EXT;
                        cmd.flash_ok = 1'b1;
                        state_next   = ST_WAIT;
                        ret_next     = ST_DONE;
                    end
                    fsmc_pkg::REQ_READ: begin
                        cmd.mem_op   = fsmc_pkg::MEM_RD;
                        cmd.mem_n    = 2'd1;
                        cmd.addr_sel = fsmc_pkg::A_EXT;
                        state_next   = ST_WAIT;
                        ret_next     = ST_RDX;
                    end
                    fsmc_pkg::REQ_KEY: begin
                        cmd.key_ld = 1'b1;
                        state_next = ST_DONE;
                    end
                    default: begin
                        if (sts.pend_nz) begin
                            cmd.rsp_sel = fsmc_pkg::SP_DEC3;
                            state_next  = ST_IRQ_WR;
                        end else begin
                            state_next = ST_FETCH;
                        end
                    end
                endcase
            end
            ST_RDX: begin
                cmd.rd_ld  = 1'b1;
                state_next = ST_DONE;
            end
            ST_IRQ_WR: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_RSP;
                cmd.wr_sel   = fsmc_pkg::W_IP;
                cmd.ip_sel   = fsmc_pkg::IP_PEND;
                cmd.pend_clr = 1'b1;
                state_next   = ST_WAIT;
                ret_next     = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.mem_op   = fsmc_pkg::MEM_RD;
                cmd.addr_sel = fsmc_pkg::A_IP;
                state_next   = ST_WAIT;
                ret_next     = ST_DECODE;
            end
            ST_DECODE: begin
                cmd.op_ld  = 1'b1;
                cmd.ip_sel = fsmc_pkg::IP_INC;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (sts.is_call) begin
                    cmd.rsp_sel = fsmc_pkg::SP_DEC3;
                    state_next  = ST_CALL_WR;
                end else if (sts.op_small) begin
                    case (sts.op_code)
                        fsmc_pkg::OP_EXIT: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_RSP;
                            cmd.rsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_LD_IP;
                        end
                        fsmc_pkg::OP_JUMP: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_IP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_LD_IP;
                        end
                        fsmc_pkg::OP_LIT: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_IP;
                            cmd.ip_sel   = fsmc_pkg::IP_INC;
                            state_next   = ST_WAIT;
                            ret_next     = ST_PUSH;
                        end
                        fsmc_pkg::OP_BRZ: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_BR;
                        end
                        fsmc_pkg::OP_TOR: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_RPUSH;
                        end
                        fsmc_pkg::OP_RFETCH: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_RSP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_PUSH;
                        end
                        fsmc_pkg::OP_RDROP: cmd.rsp_sel = fsmc_pkg::SP_INC3;
                        fsmc_pkg::OP_DUP: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_PUSH;
                        end
                        fsmc_pkg::OP_DROP: cmd.dsp_sel = fsmc_pkg::SP_INC3;
                        fsmc_pkg::OP_SWAP: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_SW1;
                        end
                        fsmc_pkg::OP_OVER: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_PUSH;
                        end
                        fsmc_pkg::OP_LESS, fsmc_pkg::OP_ADD, fsmc_pkg::OP_AND,
                        fsmc_pkg::OP_OR, fsmc_pkg::OP_XOR: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_BIN1;
                        end
                        fsmc_pkg::OP_ZEQ, fsmc_pkg::OP_SHR, fsmc_pkg::OP_EMIT: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_ALU_W;
                        end
                        fsmc_pkg::OP_CFETCH, fsmc_pkg::OP_WFETCH, fsmc_pkg::OP_FETCH: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            state_next   = ST_WAIT;
                            ret_next     = ST_FETCHT;
                        end
                        fsmc_pkg::OP_CSTORE, fsmc_pkg::OP_WSTORE, fsmc_pkg::OP_STORE: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_ST1;
                        end
                        fsmc_pkg::OP_KEY: begin
                            cmd.dsp_sel = fsmc_pkg::SP_DEC3;
                            state_next  = ST_KEY_W;
                        end
                        fsmc_pkg::OP_SPI: cmd.dsp_sel = fsmc_pkg::SP_INC6;
                        fsmc_pkg::OP_PWM: begin
                            cmd.mem_op   = fsmc_pkg::MEM_RD;
                            cmd.addr_sel = fsmc_pkg::A_DSP;
                            cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                            state_next   = ST_WAIT;
                            ret_next     = ST_PWM;
                        end
                        fsmc_pkg::OP_B9600, fsmc_pkg::OP_B38400: cmd.baud_set = 1'b1;
                        fsmc_pkg::OP_SLEEP: cmd.sleep_set = 1'b1;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_CALL_WR: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_RSP;
                cmd.wr_sel   = fsmc_pkg::W_IP;
                cmd.ip_sel   = fsmc_pkg::IP_OP;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_LD_IP: begin
                cmd.ip_sel = fsmc_pkg::IP_MDR;
                state_next = ST_DONE;
            end
            ST_PUSH: begin
                cmd.dsp_sel = fsmc_pkg::SP_DEC3;
                state_next  = ST_PUSH_W;
            end
            ST_PUSH_W, ST_TOP_W: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                cmd.wr_sel   = fsmc_pkg::W_MDR;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_BR: begin
                if (sts.mdr_zero) begin
                    cmd.mem_op   = fsmc_pkg::MEM_RD;
                    cmd.addr_sel = fsmc_pkg::A_IP;
                    state_next   = ST_WAIT;
                    ret_next     = ST_LD_IP;
                end else begin
                    cmd.ip_sel = fsmc_pkg::IP_INC;
                    state_next = ST_DONE;
                end
            end
            ST_RPUSH: begin
                cmd.rsp_sel = fsmc_pkg::SP_DEC3;
                state_next  = ST_RPUSH_W;
            end
            ST_RPUSH_W: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_RSP;
                cmd.wr_sel   = fsmc_pkg::W_MDR;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_SW1: begin
                cmd.c_ld     = 1'b1;
                cmd.mem_op   = fsmc_pkg::MEM_RD;
                cmd.addr_sel = fsmc_pkg::A_DSP3;
                state_next   = ST_WAIT;
                ret_next     = ST_SW2;
            end
            ST_SW2: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                cmd.wr_sel   = fsmc_pkg::W_MDR;
                state_next   = ST_WAIT;
                ret_next     = ST_SW3;
            end
            ST_SW3: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_DSP3;
                cmd.wr_sel   = fsmc_pkg::W_C;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_BIN1: begin
                cmd.c_ld     = 1'b1;
                cmd.mem_op   = fsmc_pkg::MEM_RD;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                state_next   = ST_WAIT;
                ret_next     = ST_ALU_W;
            end
            ST_ALU_W: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                cmd.wr_sel   = fsmc_pkg::W_ALU;
                cmd.tx_set   = (sts.op_code == fsmc_pkg::OP_EMIT);
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_FETCHT: begin
                cmd.mem_op   = fsmc_pkg::MEM_RD;
                cmd.mem_n    = size_n;
                cmd.addr_sel = fsmc_pkg::A_MDR;
                state_next   = ST_WAIT;
                ret_next     = ST_TOP_W;
            end
            ST_ST1: begin
                cmd.c_ld     = 1'b1;
                cmd.mem_op   = fsmc_pkg::MEM_RD;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                cmd.dsp_sel  = fsmc_pkg::SP_INC3;
                state_next   = ST_WAIT;
                ret_next     = ST_ST2;
            end
            ST_ST2: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.mem_n    = size_n;
                cmd.addr_sel = fsmc_pkg::A_C;
                cmd.wr_sel   = fsmc_pkg::W_MDR;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_KEY_W: begin
                cmd.mem_op   = fsmc_pkg::MEM_WR;
                cmd.addr_sel = fsmc_pkg::A_DSP;
                cmd.wr_sel   = fsmc_pkg::W_KEY;
                state_next   = ST_WAIT;
                ret_next     = ST_DONE;
            end
            ST_PWM: begin
                cmd.pv_set = 1'b1;
                state_next = ST_DONE;
            end
            ST_WAIT: begin
                if (!sts.busy) begin
                    state_next = ret_reg;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.res_ld    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.busy)
        else $error("memory engine busy while idle");
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted word not dispatched");
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_ld |=> m_tvalid_reg)
        else $error("result loaded but not presented");
    a_no_mem_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_op != fsmc_pkg::MEM_NONE) |-> !sts.busy)
        else $error("memory op issued while engine busy");
`endif

endmodule

>>> hdl/forth_stack_machine_core.sv
// Top level of the Forth stack machine core: controller plus datapath.
// In an execute word every cell access goes one byte per cycle through the
// single-port byte memory engine, and reads from the byte memories are registered.
// One word is in work at a time; the next is taken while the result waits.
// aresetn is synchronous, active low; RAM and flash contents are not cleared.
module forth_stack_machine_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // mem_address[23:0], wr_data[31:24], tx_ready[32], zero[39:33]
    input  logic [fsmc_pkg::IN_W-1:0]    s_tdata,
    // req_type[1:0]
    input  logic [fsmc_pkg::USER_W-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // read_data[7:0], next_ip[31:8], tx_valid[32], tx_data[40:33], pattern_valid[41],
    // pattern_address[65:42], baud_valid[66], baud_fast[67], sleep_request[68], zero[71:69]
    output logic [fsmc_pkg::OUT_W-1:0]   m_tdata
);

    fsmc_pkg::cmd_t    cmd;
    fsmc_pkg::status_t sts;

    fsmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsmc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

>>> tb/sv/fsmc_tb_pkg.sv
// Word layouts and the machine model shared by the stimulus and the checker.
`timescale 1ns / 100ps
package fsmc_tb_pkg;
    import fsmc_pkg::*;

    localparam int MEM_SLOTS = RAM_BYTES + FLASH_BYTES;

    typedef struct packed {
        logic [23:0] ip;
        logic [23:0] dsp;
        logic [23:0] rsp;
        logic [23:0] pend;
        logic [7:0]  key;
    } regs_t;

    typedef struct {
        regs_t    r;
        bit [7:0] mem[MEM_SLOTS];
        bit       ok[MEM_SLOTS];
    } machine_t;

    typedef struct {
        regs_t r;
        bit    missed;
        bit    fetching;
        bit    miss_fetch;
        int    miss_slot;
        int    miss_idx;
    } step_ctx_t;

    typedef struct packed {
        logic [6:0]  pad;
        logic        tx_ready;
        logic [7:0]  wr_data;
        logic [23:0] mem_address;
    } word_in_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic        sleep_request;
        logic        baud_fast;
        logic        baud_valid;
        logic [23:0] pattern_address;
        logic        pattern_valid;
        logic [7:0]  tx_data;
        logic        tx_valid;
        logic [23:0] next_ip;
        logic [7:0]  read_data;
    } word_out_t;

    function automatic int slot_of(logic [23:0] a, int i);
        if (a[23]) begin
            return RAM_BYTES + (int'(a[22:0]) + i) % FLASH_BYTES;
        end
        return (int'(a[15:0]) + i) % RAM_BYTES;
    endfunction

    function automatic logic [23:0] address_of(int s);
        if (s >= RAM_BYTES) begin
            return FLASH_BIT | 24'(s - RAM_BYTES);
        end
        return 24'(s);
    endfunction

    function automatic logic [23:0] load(ref machine_t m, ref step_ctx_t c,
                                         ref bit [7:0] wb[int], input logic [23:0] a,
                                         input int n);
        logic [23:0] v;
        bit [7:0]    b;
        int          s;
        v = '0;
        for (int i = 0; i < n; i++) begin
            s = slot_of(a, i);
            if (wb.exists(s)) begin
                b = wb[s];
            end else begin
                if (!m.ok[s] && !c.missed) begin
                    c.missed     = 1'b1;
                    c.miss_slot  = s;
                    c.miss_idx   = i;
                    c.miss_fetch = c.fetching;
                end
                b = m.mem[s];
            end
            v = v | (24'(b) << (8 * i));
        end
        return v;
    endfunction

    function automatic void store(ref bit [7:0] wb[int], input logic [23:0] a,
                                  input logic [23:0] v, input int n);
        if (a[23]) begin
            return;
        end
        for (int i = 0; i < n; i++) begin
            wb[slot_of(a, i)] = v[8*i +: 8];
        end
    endfunction

    function automatic void push_data(ref step_ctx_t c, ref bit [7:0] wb[int],
                                      input logic [23:0] v);
        c.r.dsp = c.r.dsp - CELL_THREE;
        store(wb, c.r.dsp, v, 3);
    endfunction

    function automatic void push_ret(ref step_ctx_t c, ref bit [7:0] wb[int],
                                     input logic [23:0] v);
        c.r.rsp = c.r.rsp - CELL_THREE;
        store(wb, c.r.rsp, v, 3);
    endfunction

    function automatic logic [23:0] pop_data(ref machine_t m, ref step_ctx_t c,
                                             ref bit [7:0] wb[int]);
        logic [23:0] v;
        v = load(m, c, wb, c.r.dsp, 3);
        c.r.dsp = c.r.dsp + CELL_THREE;
        return v;
    endfunction

    function automatic logic [23:0] pop_ret(ref machine_t m, ref step_ctx_t c,
                                            ref bit [7:0] wb[int]);
        logic [23:0] v;
        v = load(m, c, wb, c.r.rsp, 3);
        c.r.rsp = c.r.rsp + CELL_THREE;
        return v;
    endfunction

    function automatic void machine_reset(ref machine_t m);
        m.r.ip   = '0;
        m.r.dsp  = DSTACK_BASE | RAM_TAG;
        m.r.rsp  = RSTACK_BASE | RAM_TAG;
        m.r.pend = FLASH_BIT;
        m.r.key  = '0;
    endfunction

    function automatic word_out_t machine_step(ref machine_t m, input logic [1:0] req,
                                               input word_in_t d, input bit commit,
                                               output step_ctx_t c);
        bit [7:0]    wb[int];
        word_out_t   o;
        logic [23:0] op;
        logic [23:0] t;
        logic [23:0] v;
        o            = '0;
        c.r          = m.r;
        c.missed     = 1'b0;
        c.fetching   = 1'b0;
        c.miss_fetch = 1'b0;
        c.miss_slot  = 0;
        c.miss_idx   = 0;
        case (req)
            REQ_WRITE: wb[slot_of(d.mem_address, 0)] = d.wr_data;
            REQ_READ:  o.read_data = load(m, c, wb, d.mem_address, 1);
            REQ_KEY: begin
                c.r.key  = d.wr_data;
                c.r.pend = KEY_VECTOR;
            end
            default: begin
                if (c.r.pend != '0) begin
                    push_ret(c, wb, c.r.ip);
                    c.r.ip   = c.r.pend;
                    c.r.pend = '0;
                end
                c.fetching = 1'b1;
                op = load(m, c, wb, c.r.ip, 3);
                c.fetching = 1'b0;
                c.r.ip = c.r.ip + CELL_THREE;
                if (|op[23:22]) begin
                    push_ret(c, wb, c.r.ip);
                    c.r.ip = op;
                end else if (op <= 24'(OP_SLEEP)) begin
                    case (op[4:0])
                        OP_EXIT:   c.r.ip = pop_ret(m, c, wb);
                        OP_JUMP:   c.r.ip = load(m, c, wb, c.r.ip, 3);
                        OP_LIT: begin
                            t = load(m, c, wb, c.r.ip, 3);
                            push_data(c, wb, t);
                            c.r.ip = c.r.ip + CELL_THREE;
                        end
                        OP_BRZ: begin
                            t = pop_data(m, c, wb);
                            if (t == '0) c.r.ip = load(m, c, wb, c.r.ip, 3);
                            else c.r.ip = c.r.ip + CELL_THREE;
                        end
                        OP_TOR: begin
                            t = pop_data(m, c, wb);
                            push_ret(c, wb, t);
                        end
                        OP_RFETCH: begin
                            t = load(m, c, wb, c.r.rsp, 3);
                            push_data(c, wb, t);
                        end
                        OP_RDROP:  c.r.rsp = c.r.rsp + CELL_THREE;
                        OP_DUP: begin
                            t = load(m, c, wb, c.r.dsp, 3);
                            push_data(c, wb, t);
                        end
                        OP_DROP:   c.r.dsp = c.r.dsp + CELL_THREE;
                        OP_SWAP: begin
                            t = load(m, c, wb, c.r.dsp, 3);
                            v = load(m, c, wb, c.r.dsp + CELL_THREE, 3);
                            store(wb, c.r.dsp, v, 3);
                            store(wb, c.r.dsp + CELL_THREE, t, 3);
                        end
                        OP_OVER: begin
                            t = load(m, c, wb, c.r.dsp + CELL_THREE, 3);
                            push_data(c, wb, t);
                        end
                        OP_LESS: begin
                            t = pop_data(m, c, wb);
                            v = load(m, c, wb, c.r.dsp, 3);
                            store(wb, c.r.dsp, (v < t) ? CELL_TRUE : '0, 3);
                        end
                        OP_ZEQ: begin
                            v = load(m, c, wb, c.r.dsp, 3);
                            store(wb, c.r.dsp, (v == '0) ? CELL_TRUE : '0, 3);
                        end
                        OP_ADD, OP_AND, OP_OR, OP_XOR: begin
                            t = pop_data(m, c, wb);
                            v = load(m, c, wb, c.r.dsp, 3);
                            case (op[4:0])
                                OP_ADD:  v = v + t;
                                OP_AND:  v = v & t;
                                OP_OR:   v = v | t;
                                default: v = v ^ t;
                            endcase
                            store(wb, c.r.dsp, v, 3);
                        end
                        OP_SHR: begin
                            v = load(m, c, wb, c.r.dsp, 3);
                            store(wb, c.r.dsp, v >> 1, 3);
                        end
                        OP_CFETCH, OP_WFETCH, OP_FETCH: begin
                            v = load(m, c, wb, c.r.dsp, 3);
                            t = load(m, c, wb, v,
                                     (op[4:0] == OP_CFETCH) ? 1 :
                                     (op[4:0] == OP_WFETCH) ? 2 : 3);
                            store(wb, c.r.dsp, t, 3);
                        end
                        OP_CSTORE, OP_WSTORE, OP_STORE: begin
                            t = pop_data(m, c, wb);
                            v = pop_data(m, c, wb);
                            store(wb, t, v,
                                  (op[4:0] == OP_CSTORE) ? 1 :
                                  (op[4:0] == OP_WSTORE) ? 2 : 3);
                        end
                        OP_KEY:    push_data(c, wb, {16'd0, c.r.key});
                        OP_EMIT: begin
                            t = load(m, c, wb, c.r.dsp, 3);
                            if (d.tx_ready) begin
                                o.tx_valid = 1'b1;
                                o.tx_data  = t[7:0];
                            end
                            store(wb, c.r.dsp, d.tx_ready ? CELL_TRUE : '0, 3);
                        end
                        OP_SPI:    c.r.dsp = c.r.dsp + CELL_SIX;
                        OP_PWM: begin
                            o.pattern_address = pop_data(m, c, wb);
                            o.pattern_valid   = 1'b1;
                        end
                        OP_B9600:  o.baud_valid = 1'b1;
                        OP_B38400: begin
                            o.baud_valid = 1'b1;
                            o.baud_fast  = 1'b1;
                        end
                        OP_SLEEP:  o.sleep_request = 1'b1;
                        default: ;
                    endcase
                end
            end
        endcase
        o.next_ip = c.r.ip;
        if (commit) begin
            m.r = c.r;
            foreach (wb[s]) begin
                m.mem[s] = wb[s];
                m.ok[s]  = 1'b1;
            end
        end
        return o;
    endfunction

endpackage

>>> tb/sv/forth_stack_machine_core_checker.sv
// Checker for the Forth stack machine core: predicts each result word and compares it.
`timescale 1ns / 100ps
module forth_stack_machine_core_checker
    import fsmc_pkg::*;
    import fsmc_tb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [USER_W-1:0] s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    output int                fail_count,
    output int                words_due
);

    machine_t  model;
    word_out_t due_q[$];
    step_ctx_t ctx;
    word_out_t got;
    word_out_t want;

    assign words_due = due_q.size();

    task automatic report_mismatch(string field, logic [23:0] g, logic [23:0] e);
        $display("mismatch in %s: got %h, expected %h", field, g, e);
        fail_count++;
    endtask

    task automatic check_field(string field, logic [23:0] g, logic [23:0] e);
        if (g !== e) report_mismatch(field, g, e);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            machine_reset(model);
            due_q.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_q.push_back(machine_step(model, s_tuser, word_in_t'(s_tdata), 1'b1, ctx));
            end
            if (m_tvalid && m_tready) begin
                got = word_out_t'(m_tdata);
                if (due_q.size() == 0) begin
                    report_mismatch("unexpected word next_ip", got.next_ip, '0);
                end else begin
                    want = due_q.pop_front();
                    check_field("read_data", 24'(got.read_data), 24'(want.read_data));
                    check_field("next_ip", got.next_ip, want.next_ip);
                    check_field("tx_valid", 24'(got.tx_valid), 24'(want.tx_valid));
                    check_field("tx_data", 24'(got.tx_data), 24'(want.tx_data));
                    check_field("pattern_valid", 24'(got.pattern_valid),
                                24'(want.pattern_valid));
                    check_field("pattern_address", got.pattern_address,
                                want.pattern_address);
                    check_field("baud_valid", 24'(got.baud_valid), 24'(want.baud_valid));
                    check_field("baud_fast", 24'(got.baud_fast), 24'(want.baud_fast));
                    check_field("sleep_request", 24'(got.sleep_request),
                                24'(want.sleep_request));
                end
            end
        end
    end

endmodule

>>> tb/sv/forth_stack_machine_core_tb.sv
// Testbench top for the Forth stack machine core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module forth_stack_machine_core_tb;
    import fsmc_pkg::*;
    import fsmc_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PHASE1_WORDS = 600;
    localparam int PHASE2_WORDS = 1150;
    localparam int TOTAL_WORDS  = 1700;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [USER_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int fail_count;
    int words_due;
    int send_idle  = 0;
    int rcv_idle   = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycles     = 0;
    int sent_words = 0;

    machine_t    shadow;
    step_ctx_t   probe;
    logic [23:0] written_q[$];

    always #2 aclk = ~aclk;

    forth_stack_machine_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    forth_stack_machine_core_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("forth_stack_machine_core regression: fail");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] req, logic [23:0] addr, logic [7:0] data, logic rdy);
        word_in_t  w;
        w = {7'd0, rdy, data, addr};
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_words++;
        void'(machine_step(shadow, req, w, 1'b1, probe));
        if (req == REQ_WRITE) begin
            written_q.push_back(addr);
            if (written_q.size() > 64) void'(written_q.pop_front());
        end
    endtask

    // Fill every byte the step would read before it was written, then issue the step.
    task automatic exec_word(bit force_op, logic [23:0] op_cell, logic rdy);
        logic [23:0] eff;
        logic [7:0]  b;
        word_in_t    w;
        if (force_op) begin
            eff = (shadow.r.pend != '0) ? shadow.r.pend : shadow.r.ip;
            for (int i = 0; i < 3; i++) begin
                send_word(REQ_WRITE, address_of(slot_of(eff, i)), op_cell[8*i +: 8],
                          1'($urandom));
            end
        end
        w = {7'd0, rdy, 8'($urandom), 24'($urandom)};
        forever begin
            void'(machine_step(shadow, REQ_EXEC, w, 1'b0, probe));
            if (!probe.missed) break;
            b = 8'($urandom);
            if (probe.miss_fetch) begin
                case (probe.miss_idx)
                    0:       b = 8'($urandom_range(31));
                    1:       if ($urandom_range(9) != 0) b = '0;
                    default: if ($urandom_range(7) != 0) b = '0;
                endcase
            end
            send_word(REQ_WRITE, address_of(probe.miss_slot), b, 1'($urandom));
        end
        send_word(REQ_EXEC, w.mem_address, w.wr_data, w.tx_ready);
    endtask

    task automatic random_word();
        int          pick;
        logic [23:0] op_cell;
        pick = $urandom_range(99);
        if (pick < 10 || (pick < 18 && written_q.size() == 0)) begin
            send_word(REQ_WRITE, 24'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 18) begin
            send_word(REQ_READ, written_q[$urandom_range(written_q.size() - 1)],
                      8'($urandom), 1'($urandom));
        end else if (pick < 22) begin
            send_word(REQ_KEY, 24'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 50) begin
            op_cell = 24'($urandom_range(31));
            if ($urandom_range(9) == 0) op_cell = 24'($urandom) | RAM_TAG;
            exec_word(1'b1, op_cell, 1'($urandom));
        end else begin
            exec_word(1'b0, '0, 1'($urandom));
        end
    endtask

    initial begin
        machine_reset(shadow);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(REQ_WRITE, 24'h000000, 8'hff, 1'b0);
        send_word(REQ_READ, 24'h000000, 8'h00, 1'b0);
        send_word(REQ_WRITE, 24'hffffff, 8'h00, 1'b1);
        send_word(REQ_READ, 24'hffffff, 8'hff, 1'b1);
        exec_word(1'b1, 24'(OP_LIT), 1'b0);
        exec_word(1'b1, 24'(OP_DUP), 1'b1);
        exec_word(1'b1, 24'(OP_ADD), 1'b0);
        exec_word(1'b1, 24'(OP_EMIT), 1'b0);
        exec_word(1'b1, 24'(OP_EMIT), 1'b1);
        exec_word(1'b1, 24'(OP_WSTORE), 1'b0);
        exec_word(1'b1, 24'(OP_SPI), 1'b0);
        exec_word(1'b1, 24'(OP_PWM), 1'b0);
        exec_word(1'b1, 24'(OP_B9600), 1'b0);
        exec_word(1'b1, 24'(OP_B38400), 1'b0);
        exec_word(1'b1, 24'(OP_SLEEP), 1'b0);
        exec_word(1'b1, 24'd31, 1'b0);
        exec_word(1'b1, 24'h3fffff, 1'b0);
        send_word(REQ_KEY, 24'hffffff, 8'hff, 1'b1);
        exec_word(1'b1, 24'(OP_KEY), 1'b0);
        send_word(REQ_KEY, 24'h000000, 8'h00, 1'b0);
        exec_word(1'b1, 24'hc00000, 1'b1);
        exec_word(1'b1, 24'(OP_EXIT), 1'b0);

        send_idle = 18;
        rcv_idle  = 83;
        while (sent_words < PHASE1_WORDS) random_word();

        send_idle = 83;
        rcv_idle  = 18;
        while (sent_words < PHASE2_WORDS) random_word();

        send_idle = 0;
        rcv_idle  = 0;
        hold_seq++;
        repeat (40) random_word();
        s_tvalid <= 1'b0;
        wait (words_due == 0);
        repeat (60) @(posedge aclk);
        while (sent_words < TOTAL_WORDS) random_word();

        s_tvalid <= 1'b0;
        wait (words_due == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("forth_stack_machine_core regression: pass");
        end else begin
            $display("forth_stack_machine_core regression: fail");
        end
        $finish;
    end

endmodule
